// File: sv/dfa_pkg.sv
// Shared types and constants for the DFA multi-pattern matcher.
package dfa_pkg;

  // Automaton sizing (state and slot counts are powers of two)
  localparam int STATE_COUNT           = 4096;
  localparam int PATTERN_SLOTS         = 8192;
  localparam int MAX_MATCHES_PER_STATE = 32;
  localparam int ALPHABET_SIZE         = 256;

  localparam int STATE_W     = $clog2(STATE_COUNT);
  localparam int SLOT_W      = $clog2(PATTERN_SLOTS);
  localparam int BYTE_W      = $clog2(ALPHABET_SIZE);
  localparam int TRANS_DEPTH = STATE_COUNT * ALPHABET_SIZE;
  localparam int CNT_W       = $clog2(MAX_MATCHES_PER_STATE + 1);
  localparam int INFO_W      = CNT_W + SLOT_W;

  // Fixed field widths of the beats
  localparam int POS_W   = 40;
  localparam int ID_W    = 16;
  localparam int INDEX_W = 20;
  localparam int VALUE_W = 16;
  localparam int COUNT_W = 6;

  typedef enum logic [1:0] {
    REQ_SCAN     = 2'd0,
    REQ_WR_TRANS = 2'd1,
    REQ_WR_INFO  = 2'd2,
    REQ_WR_PID   = 2'd3
  } req_type_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_TRANS,
    ST_INFO,
    ST_EMIT
  } fsm_t;

  typedef struct packed {
    req_type_t            req_type;
    logic [BYTE_W-1:0]    text_byte;
    logic                 restart;
    logic                 owned;
    logic [POS_W-1:0]     byte_position;
    logic [INDEX_W-1:0]   entry_index;
    logic [VALUE_W-1:0]   entry_value;
    logic [COUNT_W-1:0]   entry_count;
  } req_item_t;

  typedef struct packed {
    logic [POS_W-1:0] end_position;
    logic [ID_W-1:0]  match_id;
    logic             last;
  } match_item_t;

endpackage

// File: sv/dfa_multi_pattern_matcher.sv
// Top level: Aho-Corasick DFA walker over transition, state-info and pattern-id RAMs.
// Table writes complete when accepted. A warm-up scan byte goes through TRANS to IDLE;
// an owned byte goes on through INFO and, with matches, EMIT, which sends one beat per
// match and waits while beats stall; no request is taken outside IDLE. match_valid is set
// by the output register after the dependent transition, state info and pattern id RAM reads.
// Reset (synchronous) returns the walk to the root state; the tables keep their contents.
module dfa_multi_pattern_matcher (
  input  logic                clk,
  input  logic                rst,
  input  logic                req_valid,
  output logic                req_ready,
  input  dfa_pkg::req_item_t  req_item,
  output logic                match_valid,
  input  logic                match_ready,
  output dfa_pkg::match_item_t match_item
);
  import dfa_pkg::*;

  localparam int TRANS_AW = $clog2(TRANS_DEPTH);

  fsm_t st, st_next;

  logic [STATE_W-1:0] cur_state;
  logic               owned_flag;
  logic [POS_W-1:0]   position;
  logic [CNT_W-1:0]   match_count;
  logic [SLOT_W-1:0]  slot_base;
  logic [CNT_W-1:0]   match_idx;

  // RAM ports
  logic                trans_we, trans_re;
  logic [TRANS_AW-1:0] trans_waddr, trans_raddr;
  logic [STATE_W-1:0]  trans_wdata, trans_rdata;
  logic                info_we, info_re;
  logic [STATE_W-1:0]  info_waddr, info_raddr;
  logic [INFO_W-1:0]   info_wdata, info_rdata;
  logic                pid_we, pid_re;
  logic [SLOT_W-1:0]   pid_waddr, pid_raddr;
  logic [ID_W-1:0]     pid_wdata, pid_rdata;

  logic               accept;
  logic [CNT_W-1:0]   cnt_sat;
  logic [CNT_W-1:0]   info_cnt;
  logic [SLOT_W-1:0]  info_off;
  logic [CNT_W-1:0]   idx_plus;
  logic               is_last;
  logic               out_load;

  assign req_ready = (st == ST_IDLE);
  assign accept    = req_valid && req_ready;

  assign info_cnt = info_rdata[INFO_W-1:SLOT_W];
  assign info_off = info_rdata[SLOT_W-1:0];
  assign idx_plus = match_idx + CNT_W'(1);
  assign is_last  = (idx_plus == match_count);
  assign out_load = (st == ST_EMIT) && (!match_valid || match_ready);

  assign cnt_sat = (32'(req_item.entry_count) > MAX_MATCHES_PER_STATE) ?
                   CNT_W'(MAX_MATCHES_PER_STATE) : CNT_W'(req_item.entry_count);

  // table writes, taken straight from the request beat
  assign trans_we    = accept && (req_item.req_type == REQ_WR_TRANS) &&
                       (32'(req_item.entry_index) < TRANS_DEPTH);
  assign trans_waddr = TRANS_AW'(req_item.entry_index);
  assign trans_wdata = req_item.entry_value[STATE_W-1:0];

  assign info_we    = accept && (req_item.req_type == REQ_WR_INFO) &&
                      (32'(req_item.entry_index) < STATE_COUNT);
  assign info_waddr = req_item.entry_index[STATE_W-1:0];
  assign info_wdata = {cnt_sat, req_item.entry_value[SLOT_W-1:0]};

  assign pid_we    = accept && (req_item.req_type == REQ_WR_PID) &&
                     (32'(req_item.entry_index) < PATTERN_SLOTS);
  assign pid_waddr = req_item.entry_index[SLOT_W-1:0];
  assign pid_wdata = req_item.entry_value;

  // transition lookup on a scan beat; restart walks from the root
  assign trans_re    = accept && (req_item.req_type == REQ_SCAN);
  assign trans_raddr = {(req_item.restart ? STATE_W'(0) : cur_state), req_item.text_byte};

  // state info lookup right after the transition lands
  assign info_re    = (st == ST_TRANS) && owned_flag;
  assign info_raddr = trans_rdata;

  // pattern id reads: first slot from state info, then one per emitted beat
  always_comb begin
    pid_re    = 1'b0;
    pid_raddr = info_off;
    if (st == ST_INFO) begin
      pid_re    = (info_cnt != '0);
      pid_raddr = info_off;
    end else if (out_load && !is_last) begin
      pid_re    = 1'b1;
      pid_raddr = slot_base + SLOT_W'(idx_plus);
    end
  end

  dfa_ram #(.DEPTH(TRANS_DEPTH), .WIDTH(STATE_W)) u_trans_ram (
    .clk, .we(trans_we), .waddr(trans_waddr), .wdata(trans_wdata),
    .re(trans_re), .raddr(trans_raddr), .rdata(trans_rdata)
  );

  dfa_ram #(.DEPTH(STATE_COUNT), .WIDTH(INFO_W)) u_info_ram (
    .clk, .we(info_we), .waddr(info_waddr), .wdata(info_wdata),
    .re(info_re), .raddr(info_raddr), .rdata(info_rdata)
  );

  dfa_ram #(.DEPTH(PATTERN_SLOTS), .WIDTH(ID_W)) u_pid_ram (
    .clk, .we(pid_we), .waddr(pid_waddr), .wdata(pid_wdata),
    .re(pid_re), .raddr(pid_raddr), .rdata(pid_rdata)
  );

  // sequencer state register
  always_ff @(posedge clk) begin
    if (rst) begin
      st <= ST_IDLE;
    end else begin
      st <= st_next;
    end
  end

  // next state
  always_comb begin
    st_next = st;
    unique case (st)
      ST_IDLE:  if (trans_re) st_next = ST_TRANS;
      ST_TRANS: st_next = owned_flag ? ST_INFO : ST_IDLE;
      ST_INFO:  st_next = (info_cnt == '0) ? ST_IDLE : ST_EMIT;
      ST_EMIT:  if (out_load && is_last) st_next = ST_IDLE;
      default:  st_next = ST_IDLE;
    endcase
  end

  // walk state; updated when the transition read returns
  always_ff @(posedge clk) begin
    if (rst) begin
      cur_state <= '0;
    end else if (st == ST_TRANS) begin
      cur_state <= trans_rdata;
    end
  end

  // per-byte context
  always_ff @(posedge clk) begin
    if (trans_re) begin
      owned_flag <= req_item.owned;
      position   <= req_item.byte_position;
    end
    if (st == ST_INFO) begin
      match_count <= info_cnt;
      slot_base   <= info_off;
      match_idx   <= '0;
    end else if (out_load) begin
      match_idx <= idx_plus;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      match_valid <= 1'b0;
    end else if (out_load) begin
      match_valid <= 1'b1;
    end else if (match_ready) begin
      match_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      match_item.end_position <= position;
      match_item.match_id     <= pid_rdata;
      match_item.last         <= is_last;
    end
  end

endmodule

// File: sv/dfa_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
module dfa_ram #(
  parameter int DEPTH = 1024,
  parameter int WIDTH = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read port, data held until the next read
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: dv/dfa_multi_pattern_matcher_tb.sv
// Self-checking testbench for the DFA multi-pattern matcher: table loads, scans, match beats.
module dfa_multi_pattern_matcher_tb;
  import dfa_pkg::*;

  localparam int NUM_WORK     = 8;     // states the automaton is confined to
  localparam int NUM_BYTES    = 4;     // text bytes the scans are confined to
  localparam int PID_WIN      = 48;    // pattern slots in use, wrapping past the last slot
  localparam int PID_BASE     = PATTERN_SLOTS - 16;
  localparam int BASE_SPAN    = 16;    // list offsets drawn from the window head
  localparam int DRAIN_CYCLES = 10;    // covers the block's per-byte busy time
  localparam int STALL_LIMIT  = 2000;  // cycles with no beat on either side
  localparam int HOLD_CYCLES  = 300;   // long receiver hold-off

  logic        clk;
  logic        rst;
  logic        req_valid;
  logic        req_ready;
  req_item_t   req_item;
  logic        match_valid;
  logic        match_ready;
  match_item_t match_item;

  // Mirror of the automaton tables and the walk state
  bit [STATE_W-1:0] next_state_mem [TRANS_DEPTH];
  bit [CNT_W-1:0]   match_cnt_mem  [STATE_COUNT];
  bit [SLOT_W-1:0]  list_base_mem  [STATE_COUNT];
  bit [ID_W-1:0]    pid_mem        [PATTERN_SLOTS];
  bit [STATE_W-1:0] walk_state = '0;

  match_item_t      expected_matches [$];
  match_item_t      want;
  int               errors = 0;
  int               quiet_cycles = 0;
  int               hold_req_cycles = 0;
  bit               no_idle = 1'b0;
  bit [POS_W-1:0]   next_pos;

  dfa_multi_pattern_matcher uut (
    .clk         (clk),
    .rst         (rst),
    .req_valid   (req_valid),
    .req_ready   (req_ready),
    .req_item    (req_item),
    .match_valid (match_valid),
    .match_ready (match_ready),
    .match_item  (match_item)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // The walk only ever visits these states; each row is written for every scanned byte
  function automatic bit [STATE_W-1:0] work_state(input int i);
    case (i)
      0: return 12'h000;
      1: return 12'h001;
      2: return 12'h2AA;
      3: return 12'h555;
      4: return 12'h7FF;
      5: return 12'h800;
      6: return 12'hAAA;
      default: return 12'hFFF;
    endcase
  endfunction

  // Text bytes that scans draw from
  function automatic bit [7:0] work_byte(input int i);
    case (i)
      0: return 8'h00;
      1: return 8'h01;
      2: return 8'h80;
      default: return 8'hFF;
    endcase
  endfunction

  // Pattern slot j of the window in use
  function automatic bit [SLOT_W-1:0] pid_slot(input int j);
    return SLOT_W'(PID_BASE + j);
  endfunction

  // Offset value whose list of up to the maximum count stays inside the window
  function automatic bit [VALUE_W-1:0] list_value();
    bit [2:0] hi;
    hi = 3'($urandom_range(7));
    return {hi, pid_slot($urandom_range(BASE_SPAN - 1))};
  endfunction

  function automatic bit [POS_W-1:0] rand_pos();
    bit [63:0] r;
    r = {$urandom(), $urandom()};
    return r[POS_W-1:0];
  endfunction

  // Beat with every field random; callers then set what matters
  function automatic req_item_t noise_item();
    bit [127:0] r;
    r = {$urandom(), $urandom(), $urandom(), $urandom()};
    return r[$bits(req_item_t)-1:0];
  endfunction

  function automatic req_item_t write_item(input req_type_t t, input bit [INDEX_W-1:0] idx,
                                           input bit [VALUE_W-1:0] val,
                                           input bit [COUNT_W-1:0] cnt);
    req_item_t it;
    it = noise_item();
    it.req_type    = t;
    it.entry_index = idx;
    it.entry_value = val;
    if (t == REQ_WR_INFO) it.entry_count = cnt;
    return it;
  endfunction

  function automatic req_item_t scan_item(input bit [7:0] b, input bit rs, input bit own,
                                          input bit [POS_W-1:0] pos);
    req_item_t it;
    it = noise_item();
    it.req_type      = REQ_SCAN;
    it.text_byte     = b;
    it.restart       = rs;
    it.owned         = own;
    it.byte_position = pos;
    return it;
  endfunction

  // Update the mirror with one accepted beat and queue the matches it produces
  function automatic void apply_request(input req_item_t it);
    bit [CNT_W-1:0]  n;
    bit [SLOT_W-1:0] slot;
    match_item_t     m;
    case (it.req_type)
      REQ_WR_TRANS: begin
        next_state_mem[it.entry_index] = it.entry_value[STATE_W-1:0];
      end
      REQ_WR_INFO: begin
        if (it.entry_index < STATE_COUNT) begin
          match_cnt_mem[it.entry_index[STATE_W-1:0]] =
            CNT_W'((it.entry_count > MAX_MATCHES_PER_STATE) ?
                   MAX_MATCHES_PER_STATE : it.entry_count);
          list_base_mem[it.entry_index[STATE_W-1:0]] = it.entry_value[SLOT_W-1:0];
        end
      end
      REQ_WR_PID: begin
        if (it.entry_index < PATTERN_SLOTS)
          pid_mem[it.entry_index[SLOT_W-1:0]] = it.entry_value;
      end
      default: begin
        if (it.restart) walk_state = '0;
        walk_state = next_state_mem[{walk_state, it.text_byte}];
        if (it.owned) begin
          n    = match_cnt_mem[walk_state];
          slot = list_base_mem[walk_state];
          for (int k = 0; k < n; k++) begin
            m.end_position = it.byte_position;
            m.match_id     = pid_mem[slot];
            m.last         = (k == n - 1);
            expected_matches.push_back(m);
            slot = slot + 1'b1;  // list wraps at the slot table end
          end
        end
      end
    endcase
  endfunction

  // Predict on every accepted request beat
  always @(posedge clk) begin
    if (!rst && req_valid && req_ready) apply_request(req_item);
  end

  // Compare every accepted match beat with the oldest expectation
  always @(posedge clk) begin
    if (!rst && match_valid && match_ready) begin
      if (expected_matches.size() == 0) begin
        $display("%0t: unexpected match beat, expected none, actual %h", $time, match_item);
        errors++;
      end else begin
        want = expected_matches.pop_front();
        if (match_item.end_position !== want.end_position) begin
          $display("%0t: end_position expected %h actual %h", $time,
                   want.end_position, match_item.end_position);
          errors++;
        end
        if (match_item.match_id !== want.match_id) begin
          $display("%0t: match_id expected %h actual %h", $time,
                   want.match_id, match_item.match_id);
          errors++;
        end
        if (match_item.last !== want.last) begin
          $display("%0t: last expected %b actual %b", $time, want.last, match_item.last);
          errors++;
        end
      end
    end
  end

  // Watchdog: no beat on either side for too long
  always @(posedge clk) begin
    if ((req_valid && req_ready) || (match_valid && match_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("%0t: no beat for %0d cycles", $time, quiet_cycles);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Match receiver: random ready, with an on-demand long hold-off
  initial begin
    match_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req_cycles != 0) begin
        match_ready <= 1'b0;
        repeat (hold_req_cycles) @(posedge clk);
        hold_req_cycles = 0;
      end
      match_ready <= (no_idle || $urandom_range(99) >= 13);
    end
  end

  // Offer one request beat and return once it is accepted
  task automatic send_beat(input req_item_t it);
    while (!no_idle && $urandom_range(99) < 13) begin
      req_valid <= 1'b0;
      @(posedge clk);
    end
    req_valid <= 1'b1;
    req_item  <= it;
    @(posedge clk);
    while (!req_ready) @(posedge clk);
  endtask

  // Stop offering and wait until every predicted match has arrived
  task automatic wait_drained();
    req_valid <= 1'b0;
    @(posedge clk);
    while (expected_matches.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic req_item_t rand_request(output bit counted);
    int        pick;
    bit [3:0]  hi;
    bit [7:0]  b;
    req_item_t it;
    pick    = $urandom_range(99);
    counted = 1'b1;
    hi      = 4'($urandom_range(15));
    b       = work_byte($urandom_range(NUM_BYTES - 1));
    if (pick < 72) begin
      if ($urandom_range(19) == 0) next_pos = rand_pos();
      it = scan_item(b, $urandom_range(9) == 0, $urandom_range(9) < 8, next_pos);
      next_pos++;
    end else if (pick < 84) begin
      it = write_item(REQ_WR_TRANS, {work_state($urandom_range(NUM_WORK - 1)), b},
                      {hi, work_state($urandom_range(NUM_WORK - 1))}, '0);
    end else if (pick < 91) begin
      it = write_item(REQ_WR_INFO, {8'h00, work_state($urandom_range(NUM_WORK - 1))},
                      list_value(),
                      COUNT_W'(($urandom_range(9) == 0) ? $urandom_range(63) :
                                                          $urandom_range(6)));
    end else if (pick < 98) begin
      it = write_item(REQ_WR_PID, INDEX_W'(pid_slot($urandom_range(PID_WIN - 1))),
                      VALUE_W'($urandom_range(65535)), '0);
    end else begin
      // out-of-range writes, which the block drops
      counted = 1'b0;
      if (hi[0])
        it = write_item(REQ_WR_INFO, INDEX_W'($urandom_range(20'hFFFFF, STATE_COUNT)),
                        VALUE_W'($urandom_range(65535)), COUNT_W'($urandom_range(63)));
      else
        it = write_item(REQ_WR_PID, INDEX_W'($urandom_range(20'hFFFFF, PATTERN_SLOTS)),
                        VALUE_W'($urandom_range(65535)), '0);
    end
    return it;
  endfunction

  // Rows of the working states over the scanned bytes, their output info, the slot window
  task automatic test_load_tables();
    bit [STATE_W-1:0] s;
    bit [7:0]         b;
    bit [3:0]         hi;
    bit [VALUE_W-1:0] val;
    for (int i = 0; i < NUM_WORK; i++) begin
      s = work_state(i);
      for (int j = 0; j < NUM_BYTES; j++) begin
        b   = work_byte(j);
        hi  = 4'($urandom_range(15));
        val = {hi, work_state($urandom_range(NUM_WORK - 1))};
        if (s == 0 && b == 8'h00) val = 16'h0000;
        if (s == 0 && b == 8'hFF) val = 16'hFFFF;  // reduces to state FFF
        send_beat(write_item(REQ_WR_TRANS, {s, b}, val, '0));
      end
    end
    for (int i = 0; i < NUM_WORK; i++) begin
      s = work_state(i);
      if (s == 0)
        send_beat(write_item(REQ_WR_INFO, '0, 16'h0000, 6'd0));
      else if (s == 12'hFFF)
        // count saturates; offset reduces to the last slot so the list wraps
        send_beat(write_item(REQ_WR_INFO, {8'h00, s}, 16'hFFFF, 6'd63));
      else
        send_beat(write_item(REQ_WR_INFO, {8'h00, s}, list_value(),
                             COUNT_W'($urandom_range(5, 1))));
    end
    for (int j = 0; j < PID_WIN; j++) begin
      val = VALUE_W'($urandom_range(65535));
      if (pid_slot(j) == '0) val = 16'h0000;
      if (pid_slot(j) == SLOT_W'(PATTERN_SLOTS - 1)) val = 16'hFFFF;
      send_beat(write_item(REQ_WR_PID, INDEX_W'(pid_slot(j)), val, '0));
    end
    wait_drained();
  endtask

  task automatic test_directed_cases();
    // root with no matches, then a saturated list that wraps past the last slot
    send_beat(scan_item(8'h00, 1'b1, 1'b1, '0));
    send_beat(scan_item(8'hFF, 1'b0, 1'b1, '1));
    // restart on a warm-up byte, then an owned byte from there
    send_beat(scan_item(8'hFF, 1'b1, 1'b0, 40'd1));
    send_beat(scan_item(work_byte($urandom_range(NUM_BYTES - 1)), 1'b0, 1'b1, 40'd2));
    // writes beyond the info and pattern tables are dropped
    send_beat(write_item(REQ_WR_INFO, INDEX_W'(STATE_COUNT), 16'd5, 6'd7));
    send_beat(write_item(REQ_WR_INFO, 20'hFFFFF, 16'h1234, 6'd3));
    send_beat(write_item(REQ_WR_PID, INDEX_W'(PATTERN_SLOTS), 16'hBEEF, '0));
    send_beat(write_item(REQ_WR_PID, 20'hFFFFF, 16'hCAFE, '0));
    // root list of two starting at the last slot
    send_beat(write_item(REQ_WR_INFO, '0, 16'hFFFF, 6'd2));
    send_beat(scan_item(8'h00, 1'b1, 1'b1, 40'd3));
    // next state and offset both reduced; exactly the maximum count
    send_beat(write_item(REQ_WR_TRANS, 20'h00001, 16'h1800, '0));
    send_beat(write_item(REQ_WR_INFO, 20'h00800, 16'h2000,
                         COUNT_W'(MAX_MATCHES_PER_STATE)));
    send_beat(scan_item(8'h01, 1'b1, 1'b1, 40'd4));
    send_beat(write_item(REQ_WR_PID, 20'd1, 16'h5A5A, '0));
    send_beat(scan_item(8'h01, 1'b1, 1'b1, 40'h80_0000_0000));
    send_beat(scan_item(8'h00, 1'b1, 1'b1, 40'h7F_FFFF_FFFF));
    send_beat(write_item(REQ_WR_INFO, '0, 16'h0000, 6'd0));
    send_beat(scan_item(8'h80, 1'b0, 1'b0, 40'd5));
    send_beat(scan_item(8'h01, 1'b0, 1'b1, 40'd6));
    wait_drained();
  endtask

  task automatic test_random_traffic(input int n, input bit quiet);
    int        left;
    bit        counted;
    req_item_t it;
    no_idle = quiet;
    left    = n;
    while (left > 0) begin
      it = rand_request(counted);
      send_beat(it);
      if (counted) left--;
    end
    no_idle = 1'b0;
    wait_drained();
  endtask

  // Receiver holds off while full lists keep coming, so the input must stall
  task automatic test_output_backpressure();
    send_beat(write_item(REQ_WR_TRANS, 20'h000FF, 16'hFFFF, '0));
    send_beat(write_item(REQ_WR_INFO, 20'h00FFF, list_value(), 6'd40));
    hold_req_cycles = HOLD_CYCLES;
    for (int i = 0; i < 16; i++) begin
      send_beat(scan_item(8'hFF, 1'b1, 1'b1, next_pos));
      next_pos++;
    end
    wait_drained();
  endtask

  initial begin
    rst       <= 1'b1;
    req_valid <= 1'b0;
    req_item  <= '0;
    next_pos  = rand_pos();
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    test_load_tables();
    test_directed_cases();
    test_random_traffic(40, 1'b1);
    test_output_backpressure();
    test_random_traffic(100, 1'b0);
    if (expected_matches.size() != 0) begin
      $display("%0t: %0d match beats expected but never seen", $time, expected_matches.size());
      errors++;
    end
    if (errors == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
